FILE: hw/rtl/cfcr_pkg.sv
// ----------------------------------------------------------------------------
// cfcr_pkg
// Types and constants shared by the framed command receiver modules.
// ----------------------------------------------------------------------------
`default_nettype none

package cfcr_pkg;

    localparam int PAYLOAD_BYTES = 8;
    localparam int WHEEL_COUNT   = 4;
    localparam int PAY_IDX_W     = $clog2(PAYLOAD_BYTES);

    // Smallest length that carries a full set of wheel targets.
    localparam logic [7:0] FULL_SPEED_LEN = 8'(PAYLOAD_BYTES + 3);
    // A frame must hold at least a command byte and two CRC bytes.
    localparam logic [7:0] LEN_FLOOR      = 8'd3;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // Queue between parser and dispatcher.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration register indexes.
    localparam int CFG_W   = 5;
    localparam logic [2:0] REG_START_BYTE = 3'd0;
    localparam logic [2:0] REG_LENGTH_MIN = 3'd1;
    localparam logic [2:0] REG_LENGTH_MAX = 3'd2;
    localparam logic [2:0] REG_CODE_SPEED = 3'd3;
    localparam logic [2:0] REG_CODE_STOP  = 3'd4;
    localparam logic [2:0] REG_CODE_HBEAT = 3'd5;

    typedef enum logic [2:0] {
        EV_SPEEDS    = 3'd0,
        EV_STOP      = 3'd1,
        EV_HEARTBEAT = 3'd2,
        EV_LEN_ERR   = 3'd3,
        EV_CRC_ERR   = 3'd4,
        EV_IGNORED   = 3'd5
    } t_event;

    typedef struct packed {
        logic [7:0] start_byte;
        logic [7:0] length_min;
        logic [7:0] length_max;
        logic [7:0] code_set_speeds;
        logic [7:0] code_stop;
        logic [7:0] code_heartbeat;
    } t_cfg;

    // One classified frame outcome handed from the parser to the dispatcher.
    typedef struct packed {
        t_event                         ev;
        logic [PAYLOAD_BYTES-1:0][7:0]  payload;
    } t_cmd;

    typedef struct packed {
        logic  valid;
        logic  full;
    } t_qstat;

    localparam int OUT_BITS  = 3 + 16 * WHEEL_COUNT + 32 + 32;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

endpackage

`default_nettype wire

FILE: hw/rtl/cfcr_front.sv
// ----------------------------------------------------------------------------
// cfcr_front
// Frame parser: start byte hunt, length check, CRC-16/XMODEM over the frame
// body and classification of each finished frame into a command record.
// ----------------------------------------------------------------------------
`default_nettype none

module cfcr_front (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  cfcr_pkg::t_cfg      i_cfg,
    input  wire                 i_valid,
    output logic                o_ready,
    input  wire  [7:0]          i_rx_byte,
    input  cfcr_pkg::t_qstat    i_qstat,
    output logic                o_push,
    output cfcr_pkg::t_cmd      o_cmd
);
    import cfcr_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT = 3'b001,
        PH_LEN  = 3'b010,
        PH_DATA = 3'b100
    } t_phase;

    function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    t_phase                         r_phase, n_phase;
    logic [7:0]                     r_len, n_len;
    logic [7:0]                     r_pos, n_pos;
    logic [15:0]                    r_crc, n_crc;
    logic [7:0]                     r_tail0, n_tail0;
    logic [7:0]                     r_tail1, n_tail1;
    logic [7:0]                     r_cmd, n_cmd;
    logic [PAYLOAD_BYTES-1:0][7:0]  r_payload, n_payload;

    logic        acc;
    logic [15:0] crc_next;
    logic [8:0]  pos_inc;
    logic [15:0] rx_crc;

    assign o_ready = !i_qstat.full;
    assign acc     = i_valid && o_ready;
    assign pos_inc = {1'b0, r_pos} + 9'd1;
    assign rx_crc  = {r_tail1, i_rx_byte};
    assign crc_next = (r_pos >= 8'd2) ? crc_feed(r_crc, r_tail0) : r_crc;

    always_comb begin
        n_phase   = r_phase;
        n_len     = r_len;
        n_pos     = r_pos;
        n_crc     = r_crc;
        n_tail0   = r_tail0;
        n_tail1   = r_tail1;
        n_cmd     = r_cmd;
        n_payload = r_payload;
        o_push    = 1'b0;
        o_cmd.ev      = EV_IGNORED;
        o_cmd.payload = r_payload;
        if (acc) begin
            unique case (r_phase)
                PH_LEN: begin
                    if (i_rx_byte >= LEN_FLOOR && i_rx_byte >= i_cfg.length_min
                        && i_rx_byte <= i_cfg.length_max) begin
                        n_len   = i_rx_byte;
                        n_pos   = 8'd0;
                        n_crc   = CRC_INIT;
                        n_phase = PH_DATA;
                    end else begin
                        n_phase  = PH_HUNT;
                        o_push   = 1'b1;
                        o_cmd.ev = EV_LEN_ERR;
                    end
                end
                PH_DATA: begin
                    n_crc   = crc_next;
                    n_tail0 = r_tail1;
                    n_tail1 = i_rx_byte;
                    if (r_pos == 8'd0) begin
                        n_cmd = i_rx_byte;
                    end else if (r_pos <= 8'(PAYLOAD_BYTES)) begin
                        n_payload[r_pos[PAY_IDX_W-1:0] - PAY_IDX_W'(1)] = i_rx_byte;
                    end
                    n_pos = pos_inc[7:0];
                    if (pos_inc >= {1'b0, r_len}) begin
                        n_phase = PH_HUNT;
                        o_push  = 1'b1;
                        // Priority follows the command table: speeds, stop, heartbeat.
                        if (rx_crc != crc_next) begin
                            o_cmd.ev = EV_CRC_ERR;
                        end else if (r_cmd == i_cfg.code_set_speeds) begin
                            o_cmd.ev = (r_len >= FULL_SPEED_LEN) ? EV_SPEEDS : EV_IGNORED;
                        end else if (r_cmd == i_cfg.code_stop) begin
                            o_cmd.ev = EV_STOP;
                        end else if (r_cmd == i_cfg.code_heartbeat) begin
                            o_cmd.ev = EV_HEARTBEAT;
                        end else begin
                            o_cmd.ev = EV_IGNORED;
                        end
                    end
                end
                default: begin
                    n_phase = (i_rx_byte == i_cfg.start_byte) ? PH_LEN : PH_HUNT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_len   <= 8'd0;
            r_pos   <= 8'd0;
            r_crc   <= CRC_INIT;
            r_tail0 <= 8'd0;
            r_tail1 <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_len   <= n_len;
            r_pos   <= n_pos;
            r_crc   <= n_crc;
            r_tail0 <= n_tail0;
            r_tail1 <= n_tail1;
        end
        r_cmd     <= n_cmd;
        r_payload <= n_payload;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cfcr_queue.sv
// ----------------------------------------------------------------------------
// cfcr_queue
// Short first-in first-out queue of command records between parser and
// dispatcher.
// ----------------------------------------------------------------------------
`default_nettype none

module cfcr_queue (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_push,
    input  cfcr_pkg::t_cmd      i_cmd,
    input  wire                 i_pop,
    output cfcr_pkg::t_cmd      o_cmd,
    output cfcr_pkg::t_qstat    o_qstat
);
    import cfcr_pkg::*;

    t_cmd              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, n_wr;
    logic [QPTR_W-1:0] r_rd, n_rd;
    logic [QCNT_W-1:0] r_cnt, n_cnt;

    assign o_qstat.valid = (r_cnt != '0);
    assign o_qstat.full  = (r_cnt == QCNT_W'(QDEPTH));
    assign o_cmd         = r_mem[r_rd];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_comb begin
        n_wr  = i_push ? ptr_inc(r_wr) : r_wr;
        n_rd  = i_pop  ? ptr_inc(r_rd) : r_rd;
        n_cnt = r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/cfcr_back.sv
// ----------------------------------------------------------------------------
// cfcr_back
// Dispatcher: applies each command record to the wheel targets and error
// counters and holds the result item in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cfcr_back (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  cfcr_pkg::t_qstat                    i_qstat,
    input  cfcr_pkg::t_cmd                      i_cmd,
    output logic                                o_pop,
    output logic                                o_valid,
    input  wire                                 i_ready,
    output cfcr_pkg::t_event                    o_event,
    output logic [cfcr_pkg::WHEEL_COUNT-1:0][15:0] o_targets,
    output logic [31:0]                         o_len_errs,
    output logic [31:0]                         o_crc_errs
);
    import cfcr_pkg::*;

    logic [WHEEL_COUNT-1:0][15:0] r_targets, n_targets;
    logic [31:0]                  r_len_errs, n_len_errs;
    logic [31:0]                  r_crc_errs, n_crc_errs;
    logic                         r_valid, n_valid;
    t_event                       r_event;

    assign o_pop = i_qstat.valid && (!r_valid || i_ready);

    always_comb begin
        n_targets  = r_targets;
        n_len_errs = r_len_errs;
        n_crc_errs = r_crc_errs;
        n_valid    = r_valid && !i_ready;
        if (o_pop) begin
            n_valid = 1'b1;
            unique case (i_cmd.ev)
                EV_SPEEDS: begin
                    for (int w = 0; w < WHEEL_COUNT; w++) begin
                        n_targets[w] = {i_cmd.payload[2*w], i_cmd.payload[2*w+1]};
                    end
                end
                EV_STOP:    n_targets  = '0;
                EV_LEN_ERR: n_len_errs = r_len_errs + 32'd1;
                EV_CRC_ERR: n_crc_errs = r_crc_errs + 32'd1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_targets  <= '0;
            r_len_errs <= 32'd0;
            r_crc_errs <= 32'd0;
            r_valid    <= 1'b0;
        end else begin
            r_targets  <= n_targets;
            r_len_errs <= n_len_errs;
            r_crc_errs <= n_crc_errs;
            r_valid    <= n_valid;
        end
        if (o_pop) begin
            r_event <= i_cmd.ev;
        end
    end

    // The counters and targets only change on a pop, so the live registers
    // always match the result item that is on display.
    assign o_valid    = r_valid;
    assign o_event    = r_event;
    assign o_targets  = r_targets;
    assign o_len_errs = r_len_errs;
    assign o_crc_errs = r_crc_errs;

endmodule

`default_nettype wire

FILE: hw/rtl/crc16_framed_command_receiver.sv
// ----------------------------------------------------------------------------
// crc16_framed_command_receiver
// Serial command frame receiver: start byte, bounded length, CRC-16/XMODEM,
// dispatch of set-speeds, stop and heartbeat commands.
//
//   Channel   Dir   Contents
//   s_axis    in    one received byte per item
//   m_axis    out   event, four wheel targets, length and CRC error totals
//   APB       in    six 8-bit configuration registers at 4*index
//
// One byte is taken per cycle while the queue has room; the parser does its
// CRC step in the same cycle. Each result is queued, then moved into the
// output register once it is free. Synchronous reset clears parser state,
// targets and counters. A two-entry queue decouples parser and dispatcher,
// so the input stalls only once the queue is full behind a stalled output.
// ----------------------------------------------------------------------------
`default_nettype none

module crc16_framed_command_receiver (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 s_axis_tvalid,
    output logic                s_axis_tready,
    input  wire  [7:0]          s_axis_tdata,   // [7:0] rx_byte
    output logic                m_axis_tvalid,
    input  wire                 m_axis_tready,
    // [2:0] event_res, [18:3] target_front_left, [34:19] target_front_right,
    // [50:35] target_rear_left, [66:51] target_rear_right,
    // [98:67] length_error_total, [130:99] crc_error_total, rest zero
    output logic [8*cfcr_pkg::OUT_BYTES-1:0] m_axis_tdata,
    input  wire                 psel,
    input  wire                 penable,
    input  wire                 pwrite,
    input  wire  [cfcr_pkg::CFG_W-1:0] paddr,
    input  wire  [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import cfcr_pkg::*;

    t_cfg    r_cfg;
    logic    cfg_wr;
    logic [2:0] reg_idx;

    t_cmd    push_cmd, head_cmd;
    t_qstat  qstat;
    logic    push, pop;
    t_event  ev;
    logic [WHEEL_COUNT-1:0][15:0] targets;
    logic [31:0] len_errs, crc_errs;

    assign pready  = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_byte      <= 8'd170;
            r_cfg.length_min      <= 8'd3;
            r_cfg.length_max      <= 8'd63;
            r_cfg.code_set_speeds <= 8'd1;
            r_cfg.code_stop       <= 8'd2;
            r_cfg.code_heartbeat  <= 8'd3;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_START_BYTE: r_cfg.start_byte      <= pwdata[7:0];
                REG_LENGTH_MIN: r_cfg.length_min      <= pwdata[7:0];
                REG_LENGTH_MAX: r_cfg.length_max      <= pwdata[7:0];
                REG_CODE_SPEED: r_cfg.code_set_speeds <= pwdata[7:0];
                REG_CODE_STOP:  r_cfg.code_stop       <= pwdata[7:0];
                REG_CODE_HBEAT: r_cfg.code_heartbeat  <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START_BYTE: prdata = {24'd0, r_cfg.start_byte};
            REG_LENGTH_MIN: prdata = {24'd0, r_cfg.length_min};
            REG_LENGTH_MAX: prdata = {24'd0, r_cfg.length_max};
            REG_CODE_SPEED: prdata = {24'd0, r_cfg.code_set_speeds};
            REG_CODE_STOP:  prdata = {24'd0, r_cfg.code_stop};
            REG_CODE_HBEAT: prdata = {24'd0, r_cfg.code_heartbeat};
            default:        prdata = 32'd0;
        endcase
    end

    cfcr_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (s_axis_tvalid),
        .o_ready   (s_axis_tready),
        .i_rx_byte (s_axis_tdata),
        .i_qstat   (qstat),
        .o_push    (push),
        .o_cmd     (push_cmd)
    );

    cfcr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (head_cmd),
        .o_qstat (qstat)
    );

    cfcr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_qstat    (qstat),
        .i_cmd      (head_cmd),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_event    (ev),
        .o_targets  (targets),
        .o_len_errs (len_errs),
        .o_crc_errs (crc_errs)
    );

    assign m_axis_tdata = {(8*OUT_BYTES - OUT_BITS)'(0), crc_errs, len_errs,
                           targets[3], targets[2], targets[1], targets[0], ev};

endmodule

`default_nettype wire

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the framed command receiver. A queue of serial
// bytes feeds the input stream; every accepted byte runs through a local
// frame parser that predicts the event, wheel targets and error totals.
// Each output item is compared against the oldest prediction. Several
// register settings are exercised between quiet phases, with random gaps on
// both streams and long output hold-offs that back up the input.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfcr_pkg::*;

    localparam int     OUT_W           = 8 * OUT_BYTES;
    localparam int     SETTLE_CYCLES   = 8;
    localparam int     HOLD_OFF_CYCLES = 400;
    localparam longint CYCLE_LIMIT     = 1500000;

    typedef enum logic [1:0] {
        RX_HUNT,
        RX_LENGTH,
        RX_BODY
    } t_rx_phase;

    typedef struct packed {
        t_event             ev;
        logic signed [15:0] fl;
        logic signed [15:0] fr;
        logic signed [15:0] rl;
        logic signed [15:0] rr;
        logic [31:0]        len_errs;
        logic [31:0]        crc_errs;
    } t_frame_outcome;

    logic             i_clk         = 1'b0;
    logic             i_rst_n       = 1'b0;
    logic             s_axis_tvalid = 1'b0;
    wire              s_axis_tready;
    logic [7:0]       s_axis_tdata  = '0;
    wire              m_axis_tvalid;
    logic             m_axis_tready = 1'b0;
    wire  [OUT_W-1:0] m_axis_tdata;
    logic             psel          = 1'b0;
    logic             penable       = 1'b0;
    logic             pwrite        = 1'b0;
    logic [CFG_W-1:0] paddr         = '0;
    logic [31:0]      pwdata        = '0;
    wire  [31:0]      prdata;
    wire              pready;

    crc16_framed_command_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always #1 i_clk = ~i_clk;

    // Parser shadow state.
    t_cfg               rx_cfg;
    t_rx_phase          rx_phase;
    int                 frame_len;
    int                 frame_pos;
    logic [15:0]        crc_acc;
    logic [7:0]         tail_q [2];
    logic [7:0]         cmd_code;
    logic [7:0]         payload_q [PAYLOAD_BYTES];
    logic signed [15:0] wheel_rpm [WHEEL_COUNT];
    logic [31:0]        len_err_total;
    logic [31:0]        crc_err_total;

    logic [7:0]     pending_bytes [$];
    logic [7:0]     frame_body [$];
    t_frame_outcome expected_outcomes [$];
    t_frame_outcome seen_outcome;
    t_frame_outcome want_outcome;

    int     bytes_queued_total = 0;
    int     bytes_taken_total  = 0;
    int     mismatch_count     = 0;
    longint cycle_count        = 0;
    bit     byte_taken         = 1'b0;
    bit     offering;
    bit     ready_next;
    int     send_gap  = 0;
    int     send_calm = 0;
    int     recv_gap  = 0;
    int     recv_calm = 0;
    int     hold_left = 0;
    int     stall_requests = 0;
    int     stall_served   = 0;

    function automatic logic [15:0] crc16_xmodem_step(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            r = r[15] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic string outcome_text(input t_frame_outcome o);
        return $sformatf("ev=%0d fl=%0d fr=%0d rl=%0d rr=%0d len_errs=%0d crc_errs=%0d",
                         o.ev, o.fl, o.fr, o.rl, o.rr, o.len_errs, o.crc_errs);
    endfunction

    task automatic note_mismatch(input string msg);
        if (mismatch_count < 10) $display("%s", msg);
        mismatch_count++;
    endtask

    task automatic push_outcome(input t_event ev);
        t_frame_outcome o;
        o.ev       = ev;
        o.fl       = wheel_rpm[0];
        o.fr       = wheel_rpm[1];
        o.rl       = wheel_rpm[2];
        o.rr       = wheel_rpm[3];
        o.len_errs = len_err_total;
        o.crc_errs = crc_err_total;
        expected_outcomes.push_back(o);
    endtask

    task automatic parse_byte(input logic [7:0] b);
        int          pos;
        logic [15:0] rx_crc;
        t_event      ev;
        case (rx_phase)
            RX_LENGTH: begin
                if (b >= LEN_FLOOR && b >= rx_cfg.length_min && b <= rx_cfg.length_max) begin
                    frame_len = b;
                    frame_pos = 0;
                    crc_acc   = CRC_INIT;
                    rx_phase  = RX_BODY;
                end else begin
                    rx_phase = RX_HUNT;
                    len_err_total++;
                    push_outcome(EV_LEN_ERR);
                end
            end
            RX_BODY: begin
                pos = frame_pos;
                // A byte enters the CRC only once two newer bytes show it is not a CRC byte.
                if (pos >= 2) crc_acc = crc16_xmodem_step(crc_acc, tail_q[0]);
                tail_q[0] = tail_q[1];
                tail_q[1] = b;
                if (pos == 0) begin
                    cmd_code = b;
                end else if (pos <= PAYLOAD_BYTES) begin
                    payload_q[pos-1] = b;
                end
                frame_pos = pos + 1;
                if (frame_pos >= frame_len) begin
                    rx_phase = RX_HUNT;
                    rx_crc   = {tail_q[0], tail_q[1]};
                    if (rx_crc != crc_acc) begin
                        crc_err_total++;
                        push_outcome(EV_CRC_ERR);
                    end else begin
                        if (cmd_code == rx_cfg.code_set_speeds) begin
                            if (frame_len >= FULL_SPEED_LEN) begin
                                for (int w = 0; w < WHEEL_COUNT; w++) begin
                                    wheel_rpm[w] = {payload_q[2*w], payload_q[2*w+1]};
                                end
                                ev = EV_SPEEDS;
                            end else begin
                                ev = EV_IGNORED;
                            end
                        end else if (cmd_code == rx_cfg.code_stop) begin
                            for (int w = 0; w < WHEEL_COUNT; w++) wheel_rpm[w] = '0;
                            ev = EV_STOP;
                        end else if (cmd_code == rx_cfg.code_heartbeat) begin
                            ev = EV_HEARTBEAT;
                        end else begin
                            ev = EV_IGNORED;
                        end
                        push_outcome(ev);
                    end
                end
            end
            default: begin
                rx_phase = (b == rx_cfg.start_byte) ? RX_LENGTH : RX_HUNT;
            end
        endcase
    endtask

    task automatic queue_byte(input logic [7:0] b);
        pending_bytes.push_back(b);
        bytes_queued_total++;
    endtask

    // Sends start, length, command, frame_body and the big-endian CRC.
    task automatic queue_frame(input logic [7:0] cmd, input bit bad_crc);
        logic [15:0] crc;
        queue_byte(rx_cfg.start_byte);
        queue_byte(8'(frame_body.size() + 3));
        queue_byte(cmd);
        crc = crc16_xmodem_step(CRC_INIT, cmd);
        foreach (frame_body[i]) begin
            queue_byte(frame_body[i]);
            crc = crc16_xmodem_step(crc, frame_body[i]);
        end
        if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        queue_byte(crc[15:8]);
        queue_byte(crc[7:0]);
    endtask

    task automatic run_random(input int budget);
        int         start_count;
        int         kind;
        int         lo;
        int         hi;
        int         ndata;
        int         n;
        logic [7:0] cmd;
        @(posedge i_clk);
        start_count = bytes_queued_total;
        while (bytes_queued_total - start_count < budget) begin
            kind = $urandom_range(0, 99);
            lo   = int'(rx_cfg.length_min);
            if (lo < 3) lo = 3;
            lo = lo - 3;
            hi = int'(rx_cfg.length_max) - 3;
            if (kind < 70) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: cmd = rx_cfg.code_set_speeds;
                    3, 4:    cmd = rx_cfg.code_stop;
                    5:       cmd = rx_cfg.code_heartbeat;
                    default: cmd = 8'($urandom);
                endcase
                if (hi < lo) begin
                    ndata = $urandom_range(0, 12);
                end else if ($urandom_range(0, 24) == 0) begin
                    ndata = $urandom_range(lo, hi);
                end else begin
                    ndata = $urandom_range(lo, (hi < lo + 12) ? hi : lo + 12);
                end
                frame_body.delete();
                repeat (ndata) frame_body.push_back(8'($urandom));
                queue_frame(cmd, $urandom_range(0, 99) < 15);
            end else if (kind < 80) begin
                queue_byte(rx_cfg.start_byte);
                queue_byte(8'($urandom));
            end else if (kind < 85) begin
                // Frame cut short; whatever follows is swallowed as its body.
                queue_byte(rx_cfg.start_byte);
                queue_byte(8'($urandom_range(3, 20)));
                n = $urandom_range(0, 4);
                repeat (n) queue_byte(8'($urandom));
            end else begin
                n = $urandom_range(1, 6);
                repeat (n) queue_byte(8'($urandom));
            end
        end
    endtask

    task automatic wait_until_drained();
        do @(negedge i_clk);
        while (bytes_taken_total != bytes_queued_total || expected_outcomes.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_W'({idx, 2'b00});
        pwdata  <= {24'($urandom), val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_START_BYTE: rx_cfg.start_byte      = val;
            REG_LENGTH_MIN: rx_cfg.length_min      = val;
            REG_LENGTH_MAX: rx_cfg.length_max      = val;
            REG_CODE_SPEED: rx_cfg.code_set_speeds = val;
            REG_CODE_STOP:  rx_cfg.code_stop       = val;
            default:        rx_cfg.code_heartbeat  = val;
        endcase
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[7:0] !== val) begin
            note_mismatch($sformatf("register %0d reads %0h, wrote %0h", idx, prdata[7:0], val));
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_setting(input logic [7:0] sof, input logic [7:0] lmin,
                                 input logic [7:0] lmax, input logic [7:0] c_speed,
                                 input logic [7:0] c_stop, input logic [7:0] c_hbeat);
        // Bring the parser back to hunting so the new settings start on a clean frame.
        if (rx_phase != RX_HUNT) begin
            @(posedge i_clk);
            if (rx_phase == RX_LENGTH) begin
                queue_byte(8'h00);
            end else begin
                repeat (frame_len - frame_pos) queue_byte(8'h00);
            end
            wait_until_drained();
        end
        cfg_write(REG_START_BYTE, sof);
        cfg_write(REG_LENGTH_MIN, lmin);
        cfg_write(REG_LENGTH_MAX, lmax);
        cfg_write(REG_CODE_SPEED, c_speed);
        cfg_write(REG_CODE_STOP, c_stop);
        cfg_write(REG_CODE_HBEAT, c_hbeat);
    endtask

    // Input byte driver.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            offering = s_axis_tvalid && !byte_taken;
            if (!offering && pending_bytes.size() != 0) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else begin
                    s_axis_tdata <= pending_bytes.pop_front();
                    offering = 1'b1;
                    if (send_calm > 0) begin
                        send_calm--;
                    end else begin
                        send_gap = pick_gap();
                        if ($urandom_range(0, 99) < 3) send_calm = $urandom_range(40, 200);
                    end
                end
            end
            s_axis_tvalid <= offering;
        end
    end

    // Output back-pressure, with an occasional long hold-off on request.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (stall_requests != stall_served) begin
                stall_served = stall_requests;
                hold_left    = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (recv_calm > 0) begin
                recv_calm--;
                ready_next = 1'b1;
            end else if (recv_gap > 0) begin
                recv_gap--;
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
                recv_gap   = pick_gap();
                if ($urandom_range(0, 99) < 3) recv_calm = $urandom_range(30, 150);
            end
            m_axis_tready <= ready_next;
        end
    end

    // Handshake sampling: predict on every accepted byte, check every result item.
    always @(posedge i_clk) begin
        byte_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (byte_taken) begin
            bytes_taken_total++;
            parse_byte(s_axis_tdata);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_outcome.ev       = t_event'(m_axis_tdata[2:0]);
            seen_outcome.fl       = m_axis_tdata[18:3];
            seen_outcome.fr       = m_axis_tdata[34:19];
            seen_outcome.rl       = m_axis_tdata[50:35];
            seen_outcome.rr       = m_axis_tdata[66:51];
            seen_outcome.len_errs = m_axis_tdata[98:67];
            seen_outcome.crc_errs = m_axis_tdata[130:99];
            if (expected_outcomes.size() == 0) begin
                note_mismatch({"unexpected result: ", outcome_text(seen_outcome)});
            end else begin
                want_outcome = expected_outcomes.pop_front();
                if (seen_outcome !== want_outcome) begin
                    note_mismatch({"expected ", outcome_text(want_outcome),
                                   "\n     got ", outcome_text(seen_outcome)});
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("crc16_framed_command_receiver: mismatch");
            $finish;
        end
    end

    initial begin : stimulus
        int lo_len;
        int hi_len;

        rx_cfg.start_byte      = 8'd170;
        rx_cfg.length_min      = 8'd3;
        rx_cfg.length_max      = 8'd63;
        rx_cfg.code_set_speeds = 8'd1;
        rx_cfg.code_stop       = 8'd2;
        rx_cfg.code_heartbeat  = 8'd3;
        rx_phase      = RX_HUNT;
        frame_len     = 0;
        frame_pos     = 0;
        crc_acc       = CRC_INIT;
        tail_q[0]     = '0;
        tail_q[1]     = '0;
        cmd_code      = '0;
        len_err_total = '0;
        crc_err_total = '0;
        foreach (payload_q[i]) payload_q[i] = '0;
        foreach (wheel_rpm[i]) wheel_rpm[i] = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: full set-speeds with extreme targets and start bytes in the
        // data, then heartbeat, stop, and a length byte below three.
        @(posedge i_clk);
        frame_body = {8'h80, 8'h00, 8'h7F, 8'hFF, 8'hAA, 8'hAA, 8'hFF, 8'hFF};
        queue_frame(8'd1, 1'b0);
        frame_body.delete();
        queue_frame(8'd3, 1'b0);
        queue_frame(8'd2, 1'b0);
        queue_byte(8'hAA);
        queue_byte(8'h02);
        wait_until_drained();

        run_random(180);
        wait_until_drained();

        apply_setting(8'h00, 8'd3, 8'd255, 8'hFF, 8'h00, 8'h80);
        run_random(200);
        @(posedge i_clk);
        stall_requests++;
        wait_until_drained();

        // Only the longest frame is legal here.
        apply_setting(8'hFF, 8'd255, 8'd255, 8'd1, 8'd2, 8'd3);
        run_random(250);
        wait_until_drained();

        // Bounds crossed: every length byte is rejected.
        apply_setting(8'h55, 8'd40, 8'd20, 8'd1, 8'd2, 8'd3);
        run_random(120);
        wait_until_drained();

        // All three codes equal: set-speeds wins.
        apply_setting(8'hAA, 8'd3, 8'd63, 8'h07, 8'h07, 8'h07);
        run_random(150);
        wait_until_drained();

        // Stop and heartbeat share a code; only full set-speeds frames fit.
        apply_setting(8'h3C, 8'd11, 8'd11, 8'h11, 8'h10, 8'h10);
        run_random(120);
        wait_until_drained();

        repeat (2) begin
            lo_len = $urandom_range(3, 20);
            if ($urandom_range(0, 9) == 0) hi_len = $urandom_range(3, lo_len);
            else hi_len = $urandom_range(lo_len, 40);
            apply_setting(8'($urandom), 8'(lo_len), 8'(hi_len), 8'($urandom_range(0, 7)),
                          8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)));
            run_random(150);
            @(posedge i_clk);
            stall_requests++;
            wait_until_drained();
        end

        apply_setting(8'd170, 8'd3, 8'd63, 8'd1, 8'd2, 8'd3);
        run_random(100);
        wait_until_drained();

        if (mismatch_count == 0) begin
            $display("crc16_framed_command_receiver: match");
        end else begin
            $display("crc16_framed_command_receiver: mismatch");
        end
        $finish;
    end

endmodule
